// ----- rtl/core/rslvl_pkg.sv -----
package rslvl_pkg;

	// Field and register widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned HALF_W   = SAMPLE_W - 1;
	localparam int unsigned SQ_W     = 2 * HALF_W - 1;   // (-2^14)^2 = 2^28 fits 29 bits
	localparam int unsigned SUM_W    = 40;
	localparam int unsigned ROOT_W   = SUM_W / 2;
	localparam int unsigned STEP_W   = $clog2(SUM_W);
	localparam int unsigned PAIRS_W  = 11;
	localparam int unsigned DVS_W    = PAIRS_W + 1;
	localparam int unsigned RETAIN_W = 16;
	localparam int unsigned LEVEL_W  = 16;
	localparam int unsigned OUT_W    = 15;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Frame length limit and reset values
	localparam logic [PAIRS_W-1:0]  MAX_FRAME_PAIRS   = PAIRS_W'(1024);
	localparam logic [PAIRS_W-1:0]  FRAME_PAIRS_RESET = PAIRS_W'(256);
	localparam logic [RETAIN_W-1:0] RETAIN_RESET      = RETAIN_W'(60948);

	// Largest frame RMS; a larger root is clamped to this
	localparam logic [ROOT_W-1:0] RMS_LIMIT = ROOT_W'(16384);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PAIRS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_RETAIN      = CFG_IDX_W'(1);

endpackage

// ----- rtl/core/rslvl_lane.sv -----
// One channel lane: halve the sample by arithmetic shift, square it, register.
module rslvl_lane (
	input  logic                                  clk,
	input  logic                                  load,
	input  logic signed [rslvl_pkg::SAMPLE_W-1:0] sample,
	output logic        [rslvl_pkg::SQ_W-1:0]     sq_s1
);

	logic signed [rslvl_pkg::HALF_W-1:0]  half;
	logic signed [2*rslvl_pkg::HALF_W-1:0] prod;

	assign half = rslvl_pkg::HALF_W'(sample >>> 1);
	assign prod = half * half;

	always_ff @(posedge clk) begin
		if (load) begin
			sq_s1 <= rslvl_pkg::SQ_W'(prod);
		end
	end

endmodule

// ----- rtl/core/rslvl_merge.sv -----
// Merge the two lane squares into the running frame sum (saturating).
module rslvl_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          add_en,
	input  logic                          close,
	input  logic [rslvl_pkg::SQ_W-1:0]    sq_left,
	input  logic [rslvl_pkg::SQ_W-1:0]    sq_right,
	output logic [rslvl_pkg::SUM_W-1:0]   frame_sum
);

	logic [rslvl_pkg::SUM_W-1:0] sum_q;
	logic [rslvl_pkg::SUM_W:0]   wide_sum;

	assign wide_sum = {1'b0, sum_q} + (rslvl_pkg::SUM_W + 1)'(sq_left)
		+ (rslvl_pkg::SUM_W + 1)'(sq_right);
	assign frame_sum = wide_sum[rslvl_pkg::SUM_W] ? '1 : wide_sum[rslvl_pkg::SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (add_en) begin
			// drop the sum once the frame is handed to the divider
			sum_q <= close ? '0 : frame_sum;
		end
	end

endmodule

// ----- rtl/core/rslvl_rootdiv.sv -----
// Shared iterative unit: restoring divide (one quotient bit per cycle),
// then digit-by-digit integer square root of the quotient (two bits per cycle).
module rslvl_rootdiv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rslvl_pkg::SUM_W-1:0]   dividend,
	input  logic [rslvl_pkg::DVS_W-1:0]   divisor,
	output logic                          done,
	output logic [rslvl_pkg::ROOT_W-1:0]  root
);

	typedef enum logic [2:0] {
		RD_IDLE = 3'b001,
		RD_DIV  = 3'b010,
		RD_SQRT = 3'b100
	} rd_state_t;

	localparam int unsigned SREM_W = rslvl_pkg::ROOT_W + 2;
	localparam int unsigned SSH_W  = SREM_W + 2;

	rd_state_t                         state_q;
	logic [rslvl_pkg::STEP_W-1:0]      step_q;
	logic                              done_q;
	logic [rslvl_pkg::SUM_W-1:0]       quo_q;
	logic [rslvl_pkg::DVS_W-1:0]       rem_q;
	logic [rslvl_pkg::DVS_W-1:0]       dvs_q;
	logic [SREM_W-1:0]                 srem_q;
	logic [rslvl_pkg::ROOT_W-1:0]      root_q;

	logic [rslvl_pkg::DVS_W:0] div_shift;
	logic [rslvl_pkg::DVS_W:0] div_diff;
	logic                      div_ge;
	logic [SSH_W-1:0]          sq_shift;
	logic [SSH_W-1:0]          sq_trial;
	logic [SSH_W-1:0]          sq_diff;
	logic                      sq_ge;

	always_comb begin
		div_shift = {rem_q, quo_q[rslvl_pkg::SUM_W-1]};
		div_ge    = div_shift >= {1'b0, dvs_q};
		div_diff  = div_shift - {1'b0, dvs_q};
		sq_shift  = {srem_q, quo_q[rslvl_pkg::SUM_W-1 -: 2]};
		sq_trial  = {2'b00, root_q, 2'b01};
		sq_ge     = sq_shift >= sq_trial;
		sq_diff   = sq_shift - sq_trial;
	end

	assign done = done_q;
	assign root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RD_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				RD_IDLE: begin
					if (start) begin
						state_q <= RD_DIV;
						step_q  <= '0;
					end
				end
				RD_DIV: begin
					if (step_q == rslvl_pkg::STEP_W'(rslvl_pkg::SUM_W - 1)) begin
						state_q <= RD_SQRT;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				RD_SQRT: begin
					if (step_q == rslvl_pkg::STEP_W'(rslvl_pkg::ROOT_W - 1)) begin
						state_q <= RD_IDLE;
						done_q  <= 1'b1;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: begin
					state_q <= RD_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			RD_IDLE: begin
				if (start) begin
					quo_q <= dividend;
					rem_q <= '0;
					dvs_q <= divisor;
				end
			end
			RD_DIV: begin
				quo_q <= {quo_q[rslvl_pkg::SUM_W-2:0], div_ge};
				rem_q <= div_ge ? div_diff[rslvl_pkg::DVS_W-1:0]
					: div_shift[rslvl_pkg::DVS_W-1:0];
				if (step_q == rslvl_pkg::STEP_W'(rslvl_pkg::SUM_W - 1)) begin
					srem_q <= '0;
					root_q <= '0;
				end
			end
			RD_SQRT: begin
				quo_q  <= {quo_q[rslvl_pkg::SUM_W-3:0], 2'b00};
				srem_q <= sq_ge ? sq_diff[SREM_W-1:0] : sq_shift[SREM_W-1:0];
				root_q <= {root_q[rslvl_pkg::ROOT_W-2:0], sq_ge};
			end
			default: begin
				quo_q <= quo_q;
			end
		endcase
	end

endmodule

// ----- rtl/core/stereo_rms_level_smoother_unit.sv -----
// Channel  | Handshake             | Payload
// ---------+-----------------------+----------------------------------------
// in       | in_valid / in_ready   | left_sample, right_sample (signed Q1.15)
// out      | out_valid / out_ready | frame_rms, smoothed_level (Q0.15)
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Inside a frame one stereo pair is taken per cycle; the two lanes square the
// halved samples and the merge stage adds them to the sum. The closing pair then
// passes merge, 40 divide and 20 root steps, root handoff and two smoothing steps.
// A waiting result holds in the output register; pairs are still taken, but the
// next frame close holds in the smoothing stage until that result is drained.
// Reset clears sum, count and level and loads register defaults; cfg_ready is high.
module stereo_rms_level_smoother_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,

	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [rslvl_pkg::SAMPLE_W-1:0]   left_sample,
	input  logic signed [rslvl_pkg::SAMPLE_W-1:0]   right_sample,

	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic        [rslvl_pkg::OUT_W-1:0]      frame_rms,
	output logic        [rslvl_pkg::OUT_W-1:0]      smoothed_level,

	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic        [rslvl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [rslvl_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Frame-end sequencing
	typedef enum logic [3:0] {
		T_IDLE = 4'b0001,   // taking pairs
		T_CALC = 4'b0010,   // divide and root running
		T_MUL  = 4'b0100,   // smoothing products
		T_ADD  = 4'b1000    // round, update level, load output
	} top_state_t;

	top_state_t                          state_q;

	// Configuration registers
	logic [rslvl_pkg::PAIRS_W-1:0]       frame_pairs_q;
	logic [rslvl_pkg::RETAIN_W-1:0]      retain_q;

	// Frame bookkeeping
	logic [rslvl_pkg::PAIRS_W-1:0]       pair_count_q;
	logic [rslvl_pkg::PAIRS_W-1:0]       pairs_eff;
	logic [rslvl_pkg::PAIRS_W-1:0]       count_next;
	logic                                close_now;
	logic                                in_take;

	// Lane stage
	logic                                valid_s1;
	logic                                close_s1;
	logic [rslvl_pkg::SQ_W-1:0]          sq_left_s1;
	logic [rslvl_pkg::SQ_W-1:0]          sq_right_s1;

	// Merge and shared unit
	logic [rslvl_pkg::SUM_W-1:0]         frame_sum;
	logic                                rd_start;
	logic                                rd_done;
	logic [rslvl_pkg::ROOT_W-1:0]        rd_root;

	// Smoothing
	logic [rslvl_pkg::OUT_W-1:0]         rms_q;
	logic [rslvl_pkg::LEVEL_W-1:0]       level_q;
	logic [2*rslvl_pkg::RETAIN_W-1:0]    prod_old_q;
	logic [2*rslvl_pkg::RETAIN_W-1:0]    prod_new_q;
	logic [rslvl_pkg::RETAIN_W:0]        weight_new;
	logic [rslvl_pkg::RETAIN_W:0]        weight_left;
	logic [2*rslvl_pkg::RETAIN_W:0]      smooth_sum;
	logic [rslvl_pkg::LEVEL_W-1:0]       level_next;

	// Output register
	logic                                out_valid_q;
	logic [rslvl_pkg::OUT_W-1:0]         frame_rms_q;
	logic [rslvl_pkg::OUT_W-1:0]         smoothed_q;
	logic                                out_free;

	// Clamp the frame length: zero acts as one, above the maximum acts as it.
	always_comb begin
		if (frame_pairs_q == '0) begin
			pairs_eff = rslvl_pkg::PAIRS_W'(1);
		end else if (frame_pairs_q > rslvl_pkg::MAX_FRAME_PAIRS) begin
			pairs_eff = rslvl_pkg::MAX_FRAME_PAIRS;
		end else begin
			pairs_eff = frame_pairs_q;
		end
	end

	// The count wraps at its width; a wrap also closes the frame, as does a
	// count already past a lowered frame length.
	assign count_next = pair_count_q + 1'b1;
	assign close_now  = (count_next >= pairs_eff) || (count_next == '0);

	// Hold off new pairs while a frame close is in the merge stage or the
	// shared unit and smoothing stages are busy.
	assign in_ready = (state_q == T_IDLE) && !(valid_s1 && close_s1);
	assign in_take  = in_valid && in_ready;
	assign rd_start = valid_s1 && close_s1;

	assign cfg_ready = 1'b1;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pairs_q <= rslvl_pkg::FRAME_PAIRS_RESET;
			retain_q      <= rslvl_pkg::RETAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rslvl_pkg::CFG_FRAME_PAIRS: frame_pairs_q <= cfg_data[rslvl_pkg::PAIRS_W-1:0];
				rslvl_pkg::CFG_RETAIN:      retain_q      <= cfg_data[rslvl_pkg::RETAIN_W-1:0];
				default: begin
					frame_pairs_q <= frame_pairs_q;
				end
			endcase
		end
	end

	// Pair count and lane-stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_count_q <= '0;
			valid_s1     <= 1'b0;
			close_s1     <= 1'b0;
		end else begin
			valid_s1 <= in_take;
			if (in_take) begin
				close_s1     <= close_now;
				pair_count_q <= close_now ? '0 : count_next;
			end
		end
	end

	// Two lanes, one per channel
	rslvl_lane u_lane_left (
		.clk    (clk),
		.load   (in_take),
		.sample (left_sample),
		.sq_s1  (sq_left_s1)
	);

	rslvl_lane u_lane_right (
		.clk    (clk),
		.load   (in_take),
		.sample (right_sample),
		.sq_s1  (sq_right_s1)
	);

	// Combine the lane results into the frame sum
	rslvl_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.add_en    (valid_s1),
		.close     (close_s1),
		.sq_left   (sq_left_s1),
		.sq_right  (sq_right_s1),
		.frame_sum (frame_sum)
	);

	// mean = sum / (2 * pairs), then integer root of the mean
	rslvl_rootdiv u_rootdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rd_start),
		.dividend (frame_sum),
		.divisor  ({pairs_eff, 1'b0}),
		.done     (rd_done),
		.root     (rd_root)
	);

	// Smoothing arithmetic: level = (r*old + (65536-r)*rms + half) >> 16
	assign weight_new  = (rslvl_pkg::RETAIN_W + 1)'(1) << rslvl_pkg::RETAIN_W;
	assign weight_left = weight_new - {1'b0, retain_q};
	assign smooth_sum = {1'b0, prod_old_q} + {1'b0, prod_new_q}
		+ ((2 * rslvl_pkg::RETAIN_W + 1)'(1) << (rslvl_pkg::RETAIN_W - 1));
	assign level_next = smooth_sum[2*rslvl_pkg::RETAIN_W-1 -: rslvl_pkg::LEVEL_W];

	assign out_free = !out_valid_q || out_ready;

	// Frame-end sequencer and level state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (rd_start) begin
						state_q <= T_CALC;
					end
				end
				T_CALC: begin
					if (rd_done) begin
						state_q <= T_MUL;
					end
				end
				T_MUL: begin
					state_q <= T_ADD;
				end
				T_ADD: begin
					// hold until the previous result has been taken
					if (out_free) begin
						level_q     <= level_next;
						out_valid_q <= 1'b1;
						state_q     <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	// Smoothing datapath and output payload
	always_ff @(posedge clk) begin
		if ((state_q == T_CALC) && rd_done) begin
			rms_q <= (rd_root > rslvl_pkg::RMS_LIMIT)
				? rslvl_pkg::OUT_W'(rslvl_pkg::RMS_LIMIT)
				: rd_root[rslvl_pkg::OUT_W-1:0];
		end
		if (state_q == T_MUL) begin
			prod_old_q <= retain_q * level_q;
			prod_new_q <= (2 * rslvl_pkg::RETAIN_W)'(weight_left)
				* (2 * rslvl_pkg::RETAIN_W)'(rms_q);
		end
		if ((state_q == T_ADD) && out_free) begin
			frame_rms_q <= rms_q;
			smoothed_q  <= level_next[rslvl_pkg::OUT_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_rms      = frame_rms_q;
	assign smoothed_level = smoothed_q;

endmodule

// ----- tb/sv/tb.sv -----
module tb;

	localparam int unsigned     SAMPLE_W   = rslvl_pkg::SAMPLE_W;
	localparam int unsigned     SUM_W      = rslvl_pkg::SUM_W;
	localparam int unsigned     PAIRS_W    = rslvl_pkg::PAIRS_W;
	localparam int unsigned     RETAIN_W   = rslvl_pkg::RETAIN_W;
	localparam int unsigned     LEVEL_W    = rslvl_pkg::LEVEL_W;
	localparam int unsigned     OUT_W      = rslvl_pkg::OUT_W;
	localparam int unsigned     CFG_IDX_W  = rslvl_pkg::CFG_IDX_W;
	localparam int unsigned     CFG_DATA_W = rslvl_pkg::CFG_DATA_W;

	localparam int unsigned     HALF_PERIOD     = 5;
	localparam int unsigned     RESET_CYCLES    = 10;
	// Give a frame close room to finish before touching registers.
	localparam int unsigned     SETTLE_CYCLES   = 120;
	localparam int unsigned     HOLD_OFF_CYCLES = 300;
	localparam int unsigned     IDLE_PERCENT    = 31;
	localparam int unsigned     PAIR_TARGET     = 1700;
	localparam int unsigned     LIMIT_CYCLES    = 500000;
	localparam longint unsigned SUM_CEIL        = (64'd1 << SUM_W) - 64'd1;

	// Indexes that decode to no register; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

	typedef struct packed {
		logic [OUT_W-1:0] rms;
		logic [OUT_W-1:0] level;
	} frame_result_t;

	// Track the meter: running sum, pair count and smoothed level, plus the
	// frame results that the block still owes us, oldest first.
	class level_meter_tracker;
		logic [PAIRS_W-1:0]  frame_pairs;
		logic [RETAIN_W-1:0] retain;
		longint unsigned     square_sum;
		logic [PAIRS_W-1:0]  pair_count;
		logic [LEVEL_W-1:0]  level_hold;
		frame_result_t       owed_frames[$];

		function new();
			frame_pairs = rslvl_pkg::FRAME_PAIRS_RESET;
			retain      = rslvl_pkg::RETAIN_RESET;
			square_sum  = 0;
			pair_count  = '0;
			level_hold  = '0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				rslvl_pkg::CFG_FRAME_PAIRS: frame_pairs = data[PAIRS_W-1:0];
				rslvl_pkg::CFG_RETAIN:      retain = data[RETAIN_W-1:0];
				default: ;
			endcase
		endfunction

		// Square of floor(s/2); arithmetic shift gives the floor.
		function longint unsigned halved_square(logic signed [SAMPLE_W-1:0] s);
			longint signed h;
			h = longint'(s) >>> 1;
			return h * h;
		endfunction

		function longint unsigned clamp_sum(longint unsigned v);
			return (v > SUM_CEIL) ? SUM_CEIL : v;
		endfunction

		// Bitwise integer square root, floor.
		function longint unsigned root_floor(longint unsigned v);
			longint unsigned res;
			longint unsigned bitv;
			res  = 0;
			bitv = 64'd1 << 62;
			while (bitv > v)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v   = v - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
			return res;
		endfunction

		function void take_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
			longint unsigned n;
			longint unsigned rms;
			longint unsigned lvl;
			longint unsigned w;
			n = frame_pairs;
			if (n == 0)
				n = 1;
			if (n > rslvl_pkg::MAX_FRAME_PAIRS)
				n = rslvl_pkg::MAX_FRAME_PAIRS;
			square_sum = clamp_sum(square_sum + halved_square(l));
			square_sum = clamp_sum(square_sum + halved_square(r));
			pair_count = pair_count + 1'b1;
			if (pair_count < n && pair_count != 0)
				return;
			rms = root_floor(square_sum / (2 * n));
			if (rms > rslvl_pkg::RMS_LIMIT)
				rms = rslvl_pkg::RMS_LIMIT;
			w          = retain;
			lvl        = (w * level_hold + (65536 - w) * rms + 32768) >> 16;
			level_hold = LEVEL_W'(lvl);
			square_sum = 0;
			pair_count = '0;
			owed_frames.push_back('{rms: OUT_W'(rms), level: OUT_W'(level_hold)});
		endfunction

		// Return an empty string on a match, else a description of what differs.
		function string match_frame_result(logic [OUT_W-1:0] rms, logic [OUT_W-1:0] level);
			frame_result_t e;
			string         what;
			what = "";
			if (owed_frames.size() == 0)
				return $sformatf(" result with none owed: frame_rms=%0d smoothed_level=%0d",
					rms, level);
			e = owed_frames.pop_front();
			if (rms !== e.rms)
				what = {what, $sformatf(" frame_rms got %0d want %0d", rms, e.rms)};
			if (level !== e.level)
				what = {what, $sformatf(" smoothed_level got %0d want %0d", level, e.level)};
			return what;
		endfunction

		function int unsigned frames_owed();
			return owed_frames.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic                  out_valid;
	logic                  out_ready;
	logic [OUT_W-1:0]      frame_rms;
	logic [OUT_W-1:0]      smoothed_level;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	level_meter_tracker meter = new();

	int unsigned pairs_sent    = 0;
	int unsigned mismatches    = 0;
	int unsigned cycle_count   = 0;
	bit          no_idle       = 1'b0;  // both sides run without gaps
	bit          stall_request = 1'b0;  // ask the receiver for one long hold-off

	stereo_rms_level_smoother_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.left_sample    (left_sample),
		.right_sample   (right_sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.frame_rms      (frame_rms),
		.smoothed_level (smoothed_level),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch:%s", $time, what);
	endtask

	// Check every result request taken at this edge against the oldest owed frame.
	always @(posedge clk) begin
		string what;
		if (arst_n === 1'b1 && out_valid && out_ready) begin
			what = meter.match_frame_result(frame_rms, smoothed_level);
			if (what != "")
				report_mismatch(what);
		end
	end

	// Receiver: drop ready at random, or hold it low for a long count on request.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	// Mix of extremes, full-range noise and scaled-down values so that the
	// frame RMS lands all over its range.
	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int unsigned shift);
		logic signed [SAMPLE_W-1:0] raw;
		raw = SAMPLE_W'($urandom);
		case ($urandom_range(0, 15))
			0:       return 16'sh8000;
			1:       return 16'sh7FFF;
			2, 3:    return raw;
			default: return raw >>> shift;
		endcase
	endfunction

	function automatic logic [RETAIN_W-1:0] pick_retain();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return rslvl_pkg::RETAIN_RESET;
			default: return RETAIN_W'($urandom);
		endcase
	endfunction

	// Fill the bits above the frame length field with noise; they are ignored.
	function automatic logic [CFG_DATA_W-1:0] frame_word(input logic [PAIRS_W-1:0] n);
		return {(CFG_DATA_W - PAIRS_W)'($urandom), n};
	endfunction

	// Called at a falling edge; leaves one idle cycle so valid is never
	// lowered and raised in the same step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		meter.set_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one pair; valid stays high into the next call when no gap is drawn.
	task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		left_sample  <= l;
		right_sample <= r;
		do @(posedge clk); while (!in_ready);
		meter.take_pair(l, r);
		pairs_sent++;
		@(negedge clk);
	endtask

	task automatic send_run(input int unsigned count, input int unsigned shift);
		repeat (count) send_pair(pick_sample(shift), pick_sample(shift));
	endtask

	// Drop valid, wait for every owed frame, then let any frame still in the
	// divide/root unit finish before the registers move.
	task automatic drain();
		in_valid <= 1'b0;
		while (meter.frames_owed() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int unsigned          shift;
		int unsigned          sel;
		int unsigned          n_eff;
		int unsigned          first_part;
		logic [PAIRS_W-1:0]   frame_val;
		bit                   big_done;

		big_done     = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		left_sample  = '0;
		right_sample = '0;
		cfg_valid    = 1'b0;
		cfg_index    = rslvl_pkg::CFG_FRAME_PAIRS;
		cfg_data     = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// One pair per frame with no smoothing memory: each pair shows its own
		// RMS, including the full-scale negative that lands exactly on the RMS limit.
		write_reg(rslvl_pkg::CFG_FRAME_PAIRS, 16'hF801);
		write_reg(rslvl_pkg::CFG_RETAIN, 16'h0000);
		send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh7FFF, 16'sh7FFF);
		send_pair(16'sh0000, 16'sh0000);
		send_pair(16'shFFFF, 16'sh0001);
		send_pair(16'sh0001, 16'shFFFF);
		send_pair(16'sh8000, 16'sh7FFF);
		send_pair(16'sh5555, 16'shAAAA);
		drain();

		// Heaviest retain: the level barely moves, rounding decides the step.
		write_reg(rslvl_pkg::CFG_RETAIN, 16'hFFFF);
		send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh0000, 16'sh0000);
		send_pair(16'sh4000, 16'shC000);
		drain();

		// Shorten the frame below the pairs already summed: the next pair closes it.
		write_reg(rslvl_pkg::CFG_FRAME_PAIRS, frame_word(11'd16));
		write_reg(rslvl_pkg::CFG_RETAIN, 16'h8000);
		send_run(10, 2);
		drain();
		write_reg(rslvl_pkg::CFG_FRAME_PAIRS, frame_word(11'd4));
		send_pair(16'sh7FFF, 16'sh8000);
		drain();

		// Unmapped indexes, then a zero length that must act as one.
		write_reg(CFG_SPARE_2, 16'hFFFF);
		write_reg(CFG_SPARE_3, 16'h5A5A);
		write_reg(rslvl_pkg::CFG_FRAME_PAIRS, 16'h0000);
		send_pair(16'sh1234, 16'shEDCB);
		send_pair(16'sh8000, 16'sh0000);
		drain();

		// Back-pressure: one pair per frame while the receiver holds off, so
		// the output and smoothing stages fill and input requests stall.
		write_reg(rslvl_pkg::CFG_FRAME_PAIRS, frame_word(11'd1));
		write_reg(rslvl_pkg::CFG_RETAIN, pick_retain());
		@(posedge clk);
		stall_request = 1'b1;
		@(negedge clk);
		send_run(40, 4);
		drain();

		// Random phases, mostly short frames; one long phase runs the largest
		// frame, split by a length change, without random idle gaps.
		while (pairs_sent < PAIR_TARGET) begin
			shift = $urandom_range(0, 15);
			if (!big_done && ($urandom_range(0, 19) == 0 || pairs_sent > 700)) begin
				big_done = 1'b1;
				no_idle  = 1'b1;
				write_reg(rslvl_pkg::CFG_FRAME_PAIRS, frame_word(11'd1024));
				write_reg(rslvl_pkg::CFG_RETAIN, pick_retain());
				first_part = $urandom_range(300, 700);
				send_run(first_part, shift);
				drain();
				// Above the limit acts as the limit; the frame still closes at 1024.
				if ($urandom_range(0, 1) == 0)
					frame_val = 11'd2047;
				else
					frame_val = PAIRS_W'($urandom_range(1025, 2046));
				write_reg(rslvl_pkg::CFG_FRAME_PAIRS, frame_word(frame_val));
				send_run(1024 - first_part + $urandom_range(0, 20), shift);
				no_idle = 1'b0;
				drain();
			end else begin
				sel = $urandom_range(0, 19);
				if (sel == 0)
					frame_val = '0;
				else if (sel < 4)
					frame_val = PAIRS_W'($urandom_range(17, 64));
				else
					frame_val = PAIRS_W'($urandom_range(1, 16));
				n_eff = (frame_val == 0) ? 1 : frame_val;
				write_reg(rslvl_pkg::CFG_FRAME_PAIRS, frame_word(frame_val));
				write_reg(rslvl_pkg::CFG_RETAIN, pick_retain());
				no_idle = ($urandom_range(0, 4) == 0);
				send_run(n_eff * $urandom_range(1, 3) + $urandom_range(0, n_eff - 1), shift);
				no_idle = 1'b0;
				drain();
			end
		end

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
